// ===== rtl/core/intact_run_tracker_unit_macros.svh =====
// Assertion helpers for the run tracker. They compile away under synthesis.
`ifndef INTACT_RUN_TRACKER_UNIT_MACROS_SVH
`define INTACT_RUN_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define IRT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("intact_run_tracker_unit: assertion failed");
`define IRT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("intact_run_tracker_unit: assertion failed");
`else
`define IRT_ASSERT(label, clk, rstn, prop)
`define IRT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/irt_pkg.sv =====
package irt_pkg;

    localparam int IRT_MAX_POSITIONS = 1024;

    // The destroyed map is stored as words of this many positions.
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;
    localparam int SCAN_CW    = 6;

    localparam int POS_W    = 11;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [POS_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] position;
    } irt_in_t;

    typedef struct packed {
        logic [POS_W-1:0]    run_length;
        logic [POS_W-1:0]    restored_position;
        logic [STATUS_W-1:0] status;
    } irt_out_t;

    typedef struct packed {
        logic [SCAN_CW-1:0] count;
        logic               full;
    } irt_scan_t;

endpackage

// ===== rtl/core/irt_ram.sv =====
module irt_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/irt_word_scan.sv =====
module irt_word_scan
    import irt_pkg::*;
(
    input  logic [WORD_BITS-1:0] free_bits,
    output irt_scan_t            result
);

    // Length of the run of intact positions that starts at bit 0.
    always_comb begin
        result.count = SCAN_CW'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!free_bits[i]) begin
                result.count = SCAN_CW'(i);
            end
        end
        result.full = &free_bits;
    end

endmodule

// ===== rtl/core/intact_run_tracker_unit.sv =====
// Run tracker over a line of positions with an undo stack. One word is taken and
// worked on at a time; its result goes to an output register, and the next word
// is taken while that result waits. A destroy pushes its position on the stack
// and then sets its map bit; a restore pops the stack and then clears that bit;
// an out-of-range or empty/full request goes straight to the result. A query reads
// a further 32-position map word each time its run reaches a word edge. The map is
// held as 32-position words in a memory with separate read and write ports and a
// registered read, read one word per cycle. After reset a clearing pass writes the
// map before the first word is taken; configuration writes are taken meanwhile.
`include "intact_run_tracker_unit_macros.svh"

module intact_run_tracker_unit
    import irt_pkg::*;
#(
    parameter int MAX_POSITIONS = IRT_MAX_POSITIONS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [POS_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  irt_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output irt_out_t         m_data
);

    localparam int N_W   = $clog2(MAX_POSITIONS + 1);
    localparam int IDX_W = $clog2(MAX_POSITIONS);
    localparam int WORDS = (MAX_POSITIONS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [N_W-1:0] CNT_FULL  = N_W'(MAX_POSITIONS);
    localparam logic [WA-1:0]  LAST_WORD = WA'(WORDS - 1);

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_D_WR    = 9'b000000100,
        ST_Q_CTR   = 9'b000001000,
        ST_Q_LEFT  = 9'b000010000,
        ST_Q_RIGHT = 9'b000100000,
        ST_R_POP   = 9'b001000000,
        ST_R_WR    = 9'b010000000,
        ST_RESP    = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] cfg_reg;
    logic [WA-1:0]    clr_reg, clr_next;
    logic [N_W-1:0]   cnt_reg, cnt_next;
    logic [WA-1:0]    ptr_reg, ptr_next;
    logic [WA-1:0]    home_reg, home_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [N_W-1:0]   run_reg, run_next;
    logic             right_open_reg, right_open_next;
    irt_out_t         res_reg, res_next;
    logic             m_valid_reg;
    irt_out_t         m_data_reg;
    logic             m_load;

    logic                 map_we;
    logic [WA-1:0]        map_waddr;
    logic [WORD_BITS-1:0] map_wdata;
    logic [WORD_BITS-1:0] map_rdata;
    logic                 stk_we;
    logic [IDX_W-1:0]     stk_waddr;
    logic [IDX_W-1:0]     stk_wdata;
    logic [IDX_W-1:0]     stk_rdata;

    logic                 s_fire;
    logic [N_W-1:0]       n_eff;
    logic                 in_range;
    logic [IDX_W-1:0]     in_idx;
    logic [WA-1:0]        in_word;
    logic [WORD_SHIFT-1:0] cur_bit;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] rev_free;
    logic [WORD_BITS-1:0] scan_l_in, scan_r_in;
    irt_scan_t            scan_l, scan_r;
    logic                 ctr_left_open, ctr_right_open;
    logic [N_W-1:0]       run_ctr;
    logic [N_W-1:0]       run_sum;

    assign s_fire  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Positions beyond the configured length, or beyond the storage, are boundaries.
    assign n_eff    = (int'(cfg_reg) < MAX_POSITIONS) ? N_W'(cfg_reg) : CNT_FULL;
    assign in_range = (s_data.position != '0) && (int'(s_data.position) <= int'(n_eff));
    assign in_idx   = IDX_W'(s_data.position - 11'd1);
    assign in_word  = WA'(in_idx >> WORD_SHIFT);
    assign cur_bit  = WORD_SHIFT'(idx_reg);
    assign bit_mask = {{(WORD_BITS - 1){1'b0}}, 1'b1} << cur_bit;

    // Mask of bits in the word at ptr_reg that lie at or beyond the line end.
    always_comb begin
        int rem;
        rem = int'(n_eff) - (int'(ptr_reg) << WORD_SHIFT);
        if (rem <= 0) begin
            lim_mask = '1;
        end else if (rem >= WORD_BITS) begin
            lim_mask = '0;
        end else begin
            lim_mask = {WORD_BITS{1'b1}} << rem[WORD_SHIFT-1:0];
        end
    end

    assign free_bits = ~(map_rdata | lim_mask);

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            rev_free[i] = free_bits[WORD_BITS - 1 - i];
        end
    end

    // In the home word both scans start next to the queried bit; in the walk
    // the left scan starts at the top bit of the word and the right one at bit 0.
    always_comb begin
        if (state_reg == ST_Q_CTR) begin
            scan_l_in = rev_free >> (SCAN_CW'(WORD_BITS) - SCAN_CW'(cur_bit));
            scan_r_in = free_bits >> (SCAN_CW'(cur_bit) + SCAN_CW'(1));
        end else begin
            scan_l_in = rev_free;
            scan_r_in = free_bits;
        end
    end

    irt_word_scan u_scan_l (
        .free_bits (scan_l_in),
        .result    (scan_l)
    );

    irt_word_scan u_scan_r (
        .free_bits (scan_r_in),
        .result    (scan_r)
    );

    assign ctr_left_open  = (scan_l.count == SCAN_CW'(cur_bit)) && (ptr_reg != '0);
    assign ctr_right_open = (scan_r.count == (SCAN_CW'(WORD_BITS - 1) - SCAN_CW'(cur_bit)))
                            && (ptr_reg != LAST_WORD);
    assign run_ctr = N_W'(1) + N_W'(scan_l.count) + N_W'(scan_r.count);
    assign run_sum = run_reg
                     + N_W'((state_reg == ST_Q_LEFT) ? scan_l.count : scan_r.count);

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        home_next       = home_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        right_open_next = right_open_reg;
        res_next        = res_reg;
        m_load          = 1'b0;
        map_we          = 1'b0;
        map_waddr       = ptr_reg;
        map_wdata       = map_rdata;
        stk_we          = 1'b0;
        stk_waddr       = IDX_W'(cnt_reg);
        stk_wdata       = in_idx;

        case (state_reg)
            ST_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
                clr_next  = clr_reg + WA'(1);
                if (clr_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    res_next   = '0;
                    state_next = ST_RESP;
                    idx_next   = in_idx;
                    ptr_next   = in_word;
                    home_next  = in_word;
                    case (s_data.cmd)
                        CMD_DESTROY: begin
                            if (!in_range) begin
                                res_next.status = STATUS_RANGE;
                            end else if (cnt_reg == CNT_FULL) begin
                                res_next.status = STATUS_FULL;
                            end else begin
                                stk_we     = 1'b1;
                                cnt_next   = cnt_reg + N_W'(1);
                                state_next = ST_D_WR;
                            end
                        end
                        CMD_QUERY: begin
                            if (!in_range) begin
                                res_next.status = STATUS_RANGE;
                            end else begin
                                state_next = ST_Q_CTR;
                            end
                        end
                        CMD_RESTORE: begin
                            if (cnt_reg == '0) begin
                                res_next.status = STATUS_EMPTY;
                            end else begin
                                cnt_next   = cnt_reg - N_W'(1);
                                state_next = ST_R_POP;
                            end
                        end
                        default: begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            ST_D_WR: begin
                map_we     = 1'b1;
                map_wdata  = map_rdata | bit_mask;
                state_next = ST_RESP;
            end
            ST_Q_CTR: begin
                if (!free_bits[cur_bit]) begin
                    state_next = ST_RESP;
                end else begin
                    run_next        = run_ctr;
                    right_open_next = ctr_right_open;
                    if (ctr_left_open) begin
                        ptr_next   = ptr_reg - WA'(1);
                        state_next = ST_Q_LEFT;
                    end else if (ctr_right_open) begin
                        ptr_next   = ptr_reg + WA'(1);
                        state_next = ST_Q_RIGHT;
                    end else begin
                        res_next.run_length = POS_W'(run_ctr);
                        state_next          = ST_RESP;
                    end
                end
            end
            ST_Q_LEFT: begin
                run_next = run_sum;
                if (scan_l.full && (ptr_reg != '0)) begin
                    ptr_next = ptr_reg - WA'(1);
                end else if (right_open_reg) begin
                    ptr_next   = home_reg + WA'(1);
                    state_next = ST_Q_RIGHT;
                end else begin
                    res_next.run_length = POS_W'(run_sum);
                    state_next          = ST_RESP;
                end
            end
            ST_Q_RIGHT: begin
                run_next = run_sum;
                if (scan_r.full && (ptr_reg != LAST_WORD)) begin
                    ptr_next = ptr_reg + WA'(1);
                end else begin
                    res_next.run_length = POS_W'(run_sum);
                    state_next          = ST_RESP;
                end
            end
            ST_R_POP: begin
                idx_next   = stk_rdata;
                ptr_next   = WA'(stk_rdata >> WORD_SHIFT);
                state_next = ST_R_WR;
            end
            ST_R_WR: begin
                map_we                     = 1'b1;
                map_wdata                  = map_rdata & ~bit_mask;
                res_next.restored_position = POS_W'(idx_reg) + 11'd1;
                state_next                 = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // The map is read every cycle at the word the next state will look at.
    irt_ram #(
        .WIDTH  (WORD_BITS),
        .DEPTH  (WORDS),
        .ADDR_W (WA)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (ptr_next),
        .rdata (map_rdata)
    );

    // The entry that a pop removes from the top of the stack is read here.
    irt_ram #(
        .WIDTH  (IDX_W),
        .DEPTH  (MAX_POSITIONS),
        .ADDR_W (IDX_W)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (IDX_W'(cnt_next)),
        .rdata (stk_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cfg_reg     <= CFG_RESET;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        home_reg       <= home_next;
        idx_reg        <= idx_next;
        run_reg        <= run_next;
        right_open_reg <= right_open_next;
        res_reg        <= res_next;
        if (m_load) begin
            m_data_reg <= res_reg;
        end
    end

    `IRT_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_FULL)
    `IRT_ASSERT_NEXT(a_push, aclk, aresetn, s_fire && (s_data.cmd == CMD_DESTROY) && in_range && (cnt_reg != CNT_FULL), (cnt_reg == $past(cnt_reg) + N_W'(1)) && (state_reg == ST_D_WR))
    `IRT_ASSERT_NEXT(a_pop, aclk, aresetn, s_fire && (s_data.cmd == CMD_RESTORE) && (cnt_reg != '0), (cnt_reg == $past(cnt_reg) - N_W'(1)) && (state_reg == ST_R_POP))
    `IRT_ASSERT(a_query_read_only, aclk, aresetn, ((state_reg == ST_Q_CTR) || (state_reg == ST_Q_LEFT) || (state_reg == ST_Q_RIGHT)) |-> (!map_we && !stk_we))
    `IRT_ASSERT_NEXT(a_resp_wait, aclk, aresetn, (state_reg == ST_RESP) && m_valid_reg && !m_ready, state_reg == ST_RESP)

endmodule
